// ===== rtl/fcr_pkg.sv =====
`default_nettype none
package fcr_pkg;

  localparam int PAYLOAD_LEN = 20;
  localparam int WORD_COUNT  = 5;
  localparam int WORD_W      = 32;
  localparam int BYTE_W      = 8;
  localparam int INDEX_W     = 5;
  localparam int TIMER_W     = 16;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [BYTE_W-1:0]  SYNC_RESET    = 8'hAA;
  localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd500;

  localparam logic [CFG_INDEX_W-1:0] REG_SYNC_BYTE     = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_TICKS = 1'b1;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD     = 2'd1,
    ST_TIMEOUT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_CHECK   = 2'd2
  } phase_t;

  typedef logic [WORD_COUNT-1:0][WORD_W-1:0] word_arr_t;

  typedef struct packed {
    logic              cmd;
    logic [BYTE_W-1:0] data_byte;
  } fcr_in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] x_value;
    logic signed [WORD_W-1:0] y_value;
    logic signed [WORD_W-1:0] rot_value;
    logic signed [WORD_W-1:0] aux_one;
    logic signed [WORD_W-1:0] aux_two;
    logic                     controller_present;
  } fcr_out_t;

  typedef struct packed {
    logic done;
    logic match;
  } frame_evt_t;

endpackage
`default_nettype wire

// ===== rtl/fcr_framer.sv =====
`default_nettype none
module fcr_framer (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      step,
  input  wire logic [fcr_pkg::BYTE_W-1:0] data_byte,
  input  wire logic [fcr_pkg::BYTE_W-1:0] sync_byte,
  output fcr_pkg::frame_evt_t            evt,
  output fcr_pkg::word_arr_t             words
);
  import fcr_pkg::*;

  phase_t                 phase;
  phase_t                 phase_next;
  logic [INDEX_W-1:0]     byte_index;
  logic [INDEX_W-1:0]     byte_index_next;
  logic [BYTE_W-1:0]      running_sum;
  logic [BYTE_W-1:0]      running_sum_next;
  logic                   shift_en;
  logic [BYTE_W-1:0]      payload_store [PAYLOAD_LEN];

  always_comb begin
    phase_next       = phase;
    byte_index_next  = byte_index;
    running_sum_next = running_sum;
    case (phase)
      PH_PAYLOAD: begin
        running_sum_next = running_sum + data_byte;
        byte_index_next  = byte_index + 1'b1;
        if (byte_index == INDEX_W'(PAYLOAD_LEN - 1)) begin
          phase_next = PH_CHECK;
        end
      end
      PH_CHECK: begin
        phase_next      = PH_HUNT;
        byte_index_next = '0;
      end
      default: begin
        phase_next = PH_HUNT;
        if (data_byte == sync_byte) begin
          running_sum_next = data_byte;
          byte_index_next  = '0;
          phase_next       = PH_PAYLOAD;
        end
      end
    endcase
  end

  always_comb begin
    shift_en  = step && (phase == PH_PAYLOAD);
    evt.done  = step && (phase == PH_CHECK);
    evt.match = (running_sum == data_byte);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      byte_index  <= '0;
      running_sum <= '0;
    end else if (step) begin
      phase       <= phase_next;
      byte_index  <= byte_index_next;
      running_sum <= running_sum_next;
    end
  end

  // shift in payload bytes; the first byte ends up in entry zero
  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int i = 0; i < PAYLOAD_LEN - 1; i++) begin
        payload_store[i] <= payload_store[i+1];
      end
      payload_store[PAYLOAD_LEN-1] <= data_byte;
    end
  end

  always_comb begin
    for (int k = 0; k < WORD_COUNT; k++) begin
      words[k] = {payload_store[4*k+3], payload_store[4*k+2],
                  payload_store[4*k+1], payload_store[4*k]};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/fcr_timer.sv =====
`default_nettype none
module fcr_timer (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        tick,
  input  wire logic                        clear,
  input  wire logic [fcr_pkg::TIMER_W-1:0] timeout_ticks,
  output logic                             fire
);
  import fcr_pkg::*;

  logic [TIMER_W-1:0] idle_count;
  logic [TIMER_W-1:0] idle_count_next;

  always_comb begin
    fire            = tick && (idle_count >= timeout_ticks);
    idle_count_next = idle_count;
    if (clear || fire) begin
      idle_count_next = '0;
    end else if (tick) begin
      idle_count_next = idle_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_count <= '0;
    end else begin
      idle_count <= idle_count_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/framed_command_receiver.sv =====
`default_nettype none
// Framed command receiver. Each input transfer is either a received serial byte
// or a one millisecond tick. The block hunts for the sync byte, collects a
// 20-byte payload and a checksum byte (8-bit sum of sync and payload), and on a
// match latches five little-endian signed 32-bit words and reports status 0; a
// mismatch reports status 1 and keeps the old words. A tick that finds the idle
// count at or above timeout_ticks zeroes x, y and rotation and reports status 2.
// Every result carries all latched words after the update. Throughput is one
// item per cycle unless a stalled result holds the input; the input register
// feeds the parser and the result register behind it holds each result.
// Register 0 is sync_byte, register 1 is timeout_ticks; writes are always ready.
module framed_command_receiver (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            item_valid,
  output logic                                 item_stall,
  input  wire fcr_pkg::fcr_in_t                item,
  output logic                                 result_valid,
  input  wire logic                            result_stall,
  output fcr_pkg::fcr_out_t                    result,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [fcr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [fcr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import fcr_pkg::*;

  logic               in_valid;
  fcr_in_t            in_item;
  logic               advance;
  logic               byte_step;
  logic               tick_step;
  logic [BYTE_W-1:0]  sync_byte;
  logic [TIMER_W-1:0] timeout_ticks;
  frame_evt_t         evt;
  word_arr_t          frame_words;
  word_arr_t          latched_words;
  word_arr_t          latched_words_next;
  logic               fire;
  logic               frame_ok;
  logic               has_result;
  status_t            status_next;

  assign cfg_ready  = 1'b1;
  assign advance    = in_valid && (!result_valid || !result_stall);
  assign item_stall = in_valid && !advance;
  assign byte_step  = advance && (in_item.cmd == CMD_BYTE);
  assign tick_step  = advance && (in_item.cmd == CMD_TICK);

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte     <= SYNC_RESET;
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SYNC_BYTE:     sync_byte     <= cfg_data[BYTE_W-1:0];
        REG_TIMEOUT_TICKS: timeout_ticks <= cfg_data[TIMER_W-1:0];
        default: ;
      endcase
    end
  end

  // hold the input register until it is consumed
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!item_stall) begin
      in_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      in_item <= item;
    end
  end

  fcr_framer u_framer (
    .clk       (clk),
    .rst       (rst),
    .step      (byte_step),
    .data_byte (in_item.data_byte),
    .sync_byte (sync_byte),
    .evt       (evt),
    .words     (frame_words)
  );

  fcr_timer u_timer (
    .clk           (clk),
    .rst           (rst),
    .tick          (tick_step),
    .clear         (frame_ok),
    .timeout_ticks (timeout_ticks),
    .fire          (fire)
  );

  always_comb begin
    frame_ok           = evt.done && evt.match;
    has_result         = evt.done || fire;
    latched_words_next = latched_words;
    status_next        = ST_OK;
    if (fire) begin
      latched_words_next[0] = '0;
      latched_words_next[1] = '0;
      latched_words_next[2] = '0;
      status_next           = ST_TIMEOUT;
    end else if (frame_ok) begin
      latched_words_next = frame_words;
    end else if (evt.done) begin
      status_next = ST_BAD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latched_words <= '0;
    end else begin
      latched_words <= latched_words_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= has_result;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      result.status             <= status_next;
      result.x_value            <= $signed(latched_words_next[0]);
      result.y_value            <= $signed(latched_words_next[1]);
      result.rot_value          <= $signed(latched_words_next[2]);
      result.aux_one            <= $signed(latched_words_next[3]);
      result.aux_two            <= $signed(latched_words_next[4]);
      result.controller_present <= (latched_words_next[4] != '0);
    end
  end

endmodule
`default_nettype wire

// ===== tb/framed_command_receiver_test.sv =====
`timescale 1ns / 1ps
module framed_command_receiver_test;
  import fcr_pkg::*;

  class command_frame_board;
    logic [BYTE_W-1:0]  sync_val;
    logic [TIMER_W-1:0] timeout_val;
    phase_t             frame_phase;
    int unsigned        byte_count;
    logic [BYTE_W-1:0]  check_sum;
    logic [BYTE_W-1:0]  payload [PAYLOAD_LEN];
    logic [WORD_W-1:0]  words [WORD_COUNT];
    logic [TIMER_W-1:0] idle_ticks;
    fcr_out_t           reports_due [$];
    int unsigned        fault_count;

    function new();
      sync_val = SYNC_RESET;
      timeout_val = TIMEOUT_RESET;
      frame_phase = PH_HUNT;
      byte_count = 0;
      check_sum = '0;
      foreach (payload[k]) payload[k] = '0;
      foreach (words[k]) words[k] = '0;
      idle_ticks = '0;
      fault_count = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_SYNC_BYTE: begin
          sync_val = val[BYTE_W-1:0];
        end
        REG_TIMEOUT_TICKS: begin
          timeout_val = val[TIMER_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function int unsigned pending();
      return reports_due.size();
    endfunction

    function void push_report(status_t st);
      fcr_out_t r;
      r.status = st;
      r.x_value = words[0];
      r.y_value = words[1];
      r.rot_value = words[2];
      r.aux_one = words[3];
      r.aux_two = words[4];
      r.controller_present = (words[4] != '0);
      reports_due.push_back(r);
    endfunction

    function void absorb_item(fcr_in_t it);
      if (it.cmd == CMD_TICK) begin
        if (idle_ticks >= timeout_val) begin
          words[0] = '0;
          words[1] = '0;
          words[2] = '0;
          idle_ticks = '0;
          push_report(ST_TIMEOUT);
        end else begin
          idle_ticks = idle_ticks + 1'b1;
        end
        return;
      end
      case (frame_phase)
        PH_PAYLOAD: begin
          if (byte_count < PAYLOAD_LEN) payload[byte_count] = it.data_byte;
          check_sum = check_sum + it.data_byte;
          byte_count++;
          if (byte_count >= PAYLOAD_LEN) frame_phase = PH_CHECK;
        end
        PH_CHECK: begin
          frame_phase = PH_HUNT;
          byte_count = 0;
          if (check_sum == it.data_byte) begin
            for (int k = 0; k < WORD_COUNT; k++) begin
              words[k] = {payload[4*k+3], payload[4*k+2], payload[4*k+1], payload[4*k]};
            end
            idle_ticks = '0;
            push_report(ST_OK);
          end else begin
            push_report(ST_BAD);
          end
        end
        default: begin
          frame_phase = PH_HUNT;
          if (it.data_byte == sync_val) begin
            check_sum = it.data_byte;
            byte_count = 0;
            frame_phase = PH_PAYLOAD;
          end
        end
      endcase
    endfunction

    function void compare_report(fcr_out_t got);
      fcr_out_t want;
      if (reports_due.size() == 0) begin
        fault_count++;
        if (fault_count <= 10) begin
          $display("unexpected result: status %0d x %h y %h rot %h aux1 %h aux2 %h present %b",
                   got.status, got.x_value, got.y_value, got.rot_value, got.aux_one,
                   got.aux_two, got.controller_present);
        end
        return;
      end
      want = reports_due.pop_front();
      if (got.status !== want.status || got.x_value !== want.x_value ||
          got.y_value !== want.y_value || got.rot_value !== want.rot_value ||
          got.aux_one !== want.aux_one || got.aux_two !== want.aux_two ||
          got.controller_present !== want.controller_present) begin
        fault_count++;
        if (fault_count <= 10) begin
          $display("result mismatch at %0t", $realtime);
          $display("  expected status %0d x %h y %h rot %h aux1 %h aux2 %h present %b",
                   want.status, want.x_value, want.y_value, want.rot_value, want.aux_one,
                   want.aux_two, want.controller_present);
          $display("  actual   status %0d x %h y %h rot %h aux1 %h aux2 %h present %b",
                   got.status, got.x_value, got.y_value, got.rot_value, got.aux_one,
                   got.aux_two, got.controller_present);
        end
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   item_valid = 1'b0;
  logic                   item_stall;
  fcr_in_t                item = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  fcr_out_t               result;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  command_frame_board     board;
  int unsigned            items_sent = 0;
  bit                     idling_on = 1'b1;
  bit                     hold_request = 1'b0;
  logic [BYTE_W-1:0]      current_sync = SYNC_RESET;

  framed_command_receiver dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  function automatic bit bursts_allowed();
    return idling_on && (items_sent % 96 < 64);
  endfunction

  task automatic send_item(input logic kind, input logic [BYTE_W-1:0] value);
    fcr_in_t it;
    it.cmd = kind;
    it.data_byte = value;
    item <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    board.absorb_item(it);
    items_sent++;
    if (bursts_allowed() && $urandom_range(0, 9) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic send_frame(input logic [BYTE_W-1:0] head,
                            input logic [PAYLOAD_LEN-1:0][BYTE_W-1:0] body,
                            input bit corrupt, input int tick_at);
    logic [BYTE_W-1:0] sum;
    sum = head;
    for (int k = 0; k < PAYLOAD_LEN; k++) sum = sum + body[k];
    send_item(CMD_BYTE, head);
    for (int k = 0; k < PAYLOAD_LEN; k++) begin
      if (k == tick_at) send_item(CMD_TICK, BYTE_W'($urandom));
      send_item(CMD_BYTE, body[k]);
    end
    if (corrupt) sum = sum ^ (8'd1 << $urandom_range(0, 7));
    send_item(CMD_BYTE, sum);
  endtask

  task automatic random_stretch(input int unsigned count);
    int unsigned                          stop_at;
    int unsigned                          pick;
    int                                   tick_at;
    logic [PAYLOAD_LEN-1:0][BYTE_W-1:0]   body;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        body = {$urandom, $urandom, $urandom, $urandom, $urandom};
        if ($urandom_range(0, 3) == 0) body[19:16] = '0;
        tick_at = -1;
        if ($urandom_range(0, 3) == 0) tick_at = $urandom_range(0, PAYLOAD_LEN - 1);
        send_frame(current_sync, body, $urandom_range(0, 4) == 0, tick_at);
      end else if (pick < 78) begin
        repeat ($urandom_range(1, 12)) send_item(CMD_TICK, BYTE_W'($urandom));
      end else if (pick < 92) begin
        send_item(CMD_BYTE, BYTE_W'($urandom));
      end else begin
        send_item(CMD_BYTE, current_sync);
        repeat ($urandom_range(1, PAYLOAD_LEN - 1)) send_item(CMD_BYTE, BYTE_W'($urandom));
      end
    end
    while (board.frame_phase != PH_HUNT) send_item(CMD_BYTE, ~current_sync);
  endtask

  task automatic settle(input int unsigned tail);
    item_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic retune(input logic [BYTE_W-1:0] head, input logic [TIMER_W-1:0] ticks);
    settle(4);
    cfg_valid <= 1'b1;
    cfg_index <= REG_SYNC_BYTE;
    cfg_data <= {8'h00, head};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(REG_SYNC_BYTE, {8'h00, head});
    cfg_index <= REG_TIMEOUT_TICKS;
    cfg_data <= ticks;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(REG_TIMEOUT_TICKS, ticks);
    cfg_valid <= 1'b0;
    current_sync = head;
  endtask

  initial begin
    int unsigned stall_left;
    logic        next_stall;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (result_valid === 1'b1 && !result_stall) board.compare_report(result);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = 300;
      end else if (stall_left == 0 && bursts_allowed() && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(1, 17);
      end
      next_stall = (stall_left != 0);
      if (stall_left != 0) stall_left--;
      result_stall <= next_stall;
    end
  end

  initial begin
    #400000;
    $display("FAIL framed_command_receiver");
    $finish;
  end

  initial begin
    logic [PAYLOAD_LEN-1:0][BYTE_W-1:0] body;
    board = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_item(CMD_BYTE, 8'h55);
    send_item(CMD_TICK, 8'hFF);
    body = {32'h00000001, 32'h00000000, 32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF};
    send_frame(current_sync, body, 1'b0, 3);
    body = '0;
    send_frame(current_sync, body, 1'b1, 5);
    random_stretch(140);

    retune(8'h00, 16'd1);
    hold_request = 1'b1;
    repeat (60) send_item(CMD_TICK, BYTE_W'($urandom));
    random_stretch(160);

    retune(8'hFF, 16'd0);
    random_stretch(160);

    retune(BYTE_W'($urandom), 16'hFFFF);
    random_stretch(160);

    retune(BYTE_W'($urandom), TIMER_W'($urandom_range(2, 12)));
    random_stretch(160);

    idling_on = 1'b0;
    retune(SYNC_RESET, 16'd3);
    random_stretch(160);

    settle(8);
    if (board.fault_count == 0 && board.pending() == 0) begin
      $display("PASS framed_command_receiver");
    end else begin
      $display("FAIL framed_command_receiver");
    end
    $finish;
  end

endmodule
